// ----- design/robin_hood_hash_set_unit_assert.svh -----
// Assertion macros for the Robin Hood hash set unit checker.
// Expects signals named clock and reset in the including scope.
`ifndef ROBIN_HOOD_HASH_SET_UNIT_ASSERT_SVH
`define ROBIN_HOOD_HASH_SET_UNIT_ASSERT_SVH

// same-cycle implication, masked during reset
`define RHS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rhs check failed");

// next-cycle implication, masked during reset
`define RHS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rhs check failed");

// next-cycle implication, also checked across reset
`define RHS_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rhs check failed");

`endif

// ----- design/rhs_pkg.sv -----
// Shared types and constants for the Robin Hood hash set unit.
// No dependencies.
package rhs_pkg;

   localparam int SLOTS_DEF    = 1024;
   localparam int KEY_BITS_DEF = 64;

   localparam logic [3:0]  SIZE_LOG2_RESET  = 4'd10;
   localparam logic [10:0] LOAD_LIMIT_RESET = 11'd768;

   localparam logic CSR_SIZE_LOG2  = 1'b0;
   localparam logic CSR_LOAD_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      KIND_INSERT   = 2'd0,
      KIND_CONTAINS = 2'd1,
      KIND_REMOVE   = 2'd2,
      KIND_CLEAR    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_PRESENT   = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CLEAR = 4'b0010,
      ST_RD    = 4'b0100,
      ST_EV    = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      PH_FIND  = 2'd0,
      PH_INS   = 2'd1,
      PH_SHIFT = 2'd2,
      PH_TAIL  = 2'd3
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [63:0] key;
   } req_type;

   typedef struct packed {
      logic        hit;
      status_type  status;
      logic [10:0] entry_total;
   } rsp_type;

endpackage

// ----- design/rhs_table_mem.sv -----
// Slot table memory: one write port, one read port, registered read data.
// No package dependencies.
module rhs_table_mem #(
   parameter int AW = 10,
   parameter int DW = 75
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [0:(1<<AW)-1];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/robin_hood_hash_set_unit.sv -----
// Robin Hood hash set unit top level: sequencer around the slot table memory.
// Depends on rhs_pkg and rhs_table_mem.
//
// Usage:
//   Input: raise start with req_word (kind, key); the word is taken at an edge
//   where start is high and busy is low. Kinds: insert, contains, remove, clear.
//   Output: one result word per input on rsp_word, marked by rsp_valid for
//   one cycle; the receiver cannot stall, so results are never held.
//   Config: csr_valid with csr_index/csr_data; csr_ready is always high.
//   Index 0 sets table_size_log2 and empties the table; index 1 sets load_limit.
// Sequence:
//   Each probed slot takes a memory read (ST_RD), then an evaluate and write
//   back (ST_EV). Insert probes the search run, then the placement run.
//   Contains probes the search run; Remove, the search run and shifted run.
//   An insert refused as full answers in the cycle after acceptance.
//   Clear and a size write run a clearing pass over all SLOTS slots.
// Reset:
//   Reset starts the clearing pass; busy stays high until every slot is written.
module robin_hood_hash_set_unit #(
   parameter int SLOTS    = rhs_pkg::SLOTS_DEF,
   parameter int KEY_BITS = rhs_pkg::KEY_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rhs_pkg::req_type req_word,
   output logic             rsp_valid,
   output rhs_pkg::rsp_type rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [10:0]      csr_data
);

   localparam int IDXW = $clog2(SLOTS);
   localparam int CNTW = IDXW + 1;
   localparam int EW   = 1 + IDXW + KEY_BITS;

   rhs_pkg::state_type state_ff, state_in;
   rhs_pkg::phase_type phase_ff, phase_in;
   rhs_pkg::kind_type  kind_ff, kind_in;
   logic [KEY_BITS-1:0] key_ff, key_in, carry_ff, carry_in;
   logic [IDXW-1:0]     idx_ff, idx_in, last_ff, last_in, clr_ff, clr_in;
   logic [CNTW-1:0]     dist_ff, dist_in, step_ff, step_in, count_ff, count_in;
   logic [3:0]          lg_ff, lg_in;
   logic [10:0]         limit_ff, limit_in;
   logic                clr_rsp_ff, clr_rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rhs_pkg::rsp_type    rsp_ff, rsp_in;

   logic                we;
   logic [IDXW-1:0]     wa;
   logic [EW-1:0]       wd, rdata;
   logic [3:0]          lg_eff;
   logic [CNTW-1:0]     size;
   logic [IDXW-1:0]     mask, next_idx, home_req, home_key;
   logic [KEY_BITS-1:0] key_req, rkey;
   logic [IDXW-1:0]     rdist;
   logic                rv, miss, found, not_found, full;

   rhs_table_mem #(.AW(IDXW), .DW(EW)) u_mem (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (wa),
      .wr_data (wd),
      .rd_addr (idx_ff),
      .rd_data (rdata)
   );

   always_comb begin
      lg_eff = (lg_ff == 4'd0) ? 4'd1 : lg_ff;
      if (32'(lg_eff) >= IDXW) begin
         size = CNTW'(SLOTS);
         mask = '1;
      end else begin
         size = CNTW'(1) << lg_eff;
         mask = IDXW'(size - CNTW'(1));
      end
   end

   assign key_req  = KEY_BITS'(req_word.key);
   assign home_req = IDXW'(64'(key_req)) & mask;
   assign home_key = IDXW'(64'(key_ff)) & mask;
   assign next_idx = (idx_ff + IDXW'(1)) & mask;
   assign rv       = rdata[EW-1];
   assign rdist    = rdata[KEY_BITS +: IDXW];
   assign rkey     = rdata[KEY_BITS-1:0];
   assign miss     = !rv || (dist_ff > CNTW'(rdist));
   assign found    = !miss && (rkey == key_ff);
   assign not_found = !found && (miss || (dist_ff + CNTW'(1) == size));
   assign full     = (32'(count_ff) >= 32'(limit_ff)) || (count_ff >= size);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      carry_in     = carry_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      clr_in       = clr_ff;
      dist_in      = dist_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      lg_in        = lg_ff;
      limit_in     = limit_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      we           = 1'b0;
      wa           = idx_ff;
      wd           = '0;
      case (state_ff)
         rhs_pkg::ST_IDLE: begin
            if (start) begin
               kind_in  = req_word.kind;
               key_in   = key_req;
               carry_in = key_req;
               idx_in   = home_req;
               dist_in  = '0;
               step_in  = '0;
               phase_in = rhs_pkg::PH_FIND;
               case (req_word.kind)
                  rhs_pkg::KIND_INSERT: begin
                     if (full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.hit    = 1'b0;
                        rsp_in.status = rhs_pkg::STAT_FULL;
                     end else begin
                        state_in = rhs_pkg::ST_RD;
                     end
                  end
                  rhs_pkg::KIND_CONTAINS, rhs_pkg::KIND_REMOVE: begin
                     state_in = rhs_pkg::ST_RD;
                  end
                  rhs_pkg::KIND_CLEAR: begin
                     state_in   = rhs_pkg::ST_CLEAR;
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     count_in   = '0;
                  end
                  default: state_in = rhs_pkg::ST_IDLE;
               endcase
            end
         end
         rhs_pkg::ST_CLEAR: begin
            we     = 1'b1;
            wa     = clr_ff;
            clr_in = clr_ff + IDXW'(1);
            if (clr_ff == IDXW'(SLOTS - 1)) begin
               state_in = rhs_pkg::ST_IDLE;
               if (clr_rsp_ff) begin
                  clr_rsp_in    = 1'b0;
                  rsp_valid_in  = 1'b1;
                  rsp_in.hit    = 1'b0;
                  rsp_in.status = rhs_pkg::STAT_DONE;
               end
            end
         end
         rhs_pkg::ST_RD: begin
            if (phase_ff == rhs_pkg::PH_TAIL) begin
               we            = 1'b1;
               wa            = last_ff;
               count_in      = (count_ff != '0) ? count_ff - CNTW'(1) : count_ff;
               rsp_valid_in  = 1'b1;
               rsp_in.hit    = 1'b1;
               rsp_in.status = rhs_pkg::STAT_DONE;
               state_in      = rhs_pkg::ST_IDLE;
            end else begin
               state_in = rhs_pkg::ST_EV;
            end
         end
         rhs_pkg::ST_EV: begin
            state_in = rhs_pkg::ST_RD;
            case (phase_ff)
               rhs_pkg::PH_FIND: begin
                  if (found) begin
                     case (kind_ff)
                        rhs_pkg::KIND_REMOVE: begin
                           phase_in = rhs_pkg::PH_SHIFT;
                           last_in  = idx_ff;
                           idx_in   = next_idx;
                           step_in  = '0;
                        end
                        rhs_pkg::KIND_INSERT: begin
                           rsp_valid_in  = 1'b1;
                           rsp_in.hit    = 1'b0;
                           rsp_in.status = rhs_pkg::STAT_PRESENT;
                           state_in      = rhs_pkg::ST_IDLE;
                        end
                        default: begin
                           rsp_valid_in  = 1'b1;
                           rsp_in.hit    = 1'b1;
                           rsp_in.status = rhs_pkg::STAT_DONE;
                           state_in      = rhs_pkg::ST_IDLE;
                        end
                     endcase
                  end else if (not_found) begin
                     if (kind_ff == rhs_pkg::KIND_INSERT) begin
                        phase_in = rhs_pkg::PH_INS;
                        idx_in   = home_key;
                        dist_in  = '0;
                        step_in  = '0;
                        carry_in = key_ff;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.hit    = 1'b0;
                        rsp_in.status = rhs_pkg::STAT_NOT_FOUND;
                        state_in      = rhs_pkg::ST_IDLE;
                     end
                  end else begin
                     dist_in = dist_ff + CNTW'(1);
                     idx_in  = next_idx;
                  end
               end
               rhs_pkg::PH_INS: begin
                  if (!rv) begin
                     we            = 1'b1;
                     wd            = {1'b1, IDXW'(dist_ff), carry_ff};
                     count_in      = count_ff + CNTW'(1);
                     rsp_valid_in  = 1'b1;
                     rsp_in.hit    = 1'b1;
                     rsp_in.status = rhs_pkg::STAT_DONE;
                     state_in      = rhs_pkg::ST_IDLE;
                  end else begin
                     if (dist_ff > CNTW'(rdist)) begin
                        we       = 1'b1;
                        wd       = {1'b1, IDXW'(dist_ff), carry_ff};
                        carry_in = rkey;
                        dist_in  = CNTW'(rdist) + CNTW'(1);
                     end else begin
                        dist_in = dist_ff + CNTW'(1);
                     end
                     idx_in  = next_idx;
                     step_in = step_ff + CNTW'(1);
                     if (step_ff + CNTW'(1) == size) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.hit    = 1'b1;
                        rsp_in.status = rhs_pkg::STAT_DONE;
                        state_in      = rhs_pkg::ST_IDLE;
                     end
                  end
               end
               rhs_pkg::PH_SHIFT: begin
                  we = 1'b1;
                  wa = last_ff;
                  if (!rv || rdist == '0) begin
                     count_in      = (count_ff != '0) ? count_ff - CNTW'(1) : count_ff;
                     rsp_valid_in  = 1'b1;
                     rsp_in.hit    = 1'b1;
                     rsp_in.status = rhs_pkg::STAT_DONE;
                     state_in      = rhs_pkg::ST_IDLE;
                  end else begin
                     wd      = {1'b1, rdist - IDXW'(1), rkey};
                     last_in = idx_ff;
                     idx_in  = next_idx;
                     step_in = step_ff + CNTW'(1);
                     if (step_ff + CNTW'(1) == size) begin
                        phase_in = rhs_pkg::PH_TAIL;
                     end
                  end
               end
               default: state_in = rhs_pkg::ST_IDLE;
            endcase
         end
         default: state_in = rhs_pkg::ST_IDLE;
      endcase
      if (csr_valid) begin
         case (csr_index)
            rhs_pkg::CSR_SIZE_LOG2: begin
               lg_in    = csr_data[3:0];
               state_in = rhs_pkg::ST_CLEAR;
               clr_in   = '0;
               count_in = '0;
            end
            rhs_pkg::CSR_LOAD_LIMIT: limit_in = csr_data;
            default: limit_in = limit_ff;
         endcase
      end
      rsp_in.entry_total = 11'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rhs_pkg::ST_CLEAR;
         phase_ff     <= rhs_pkg::PH_FIND;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         count_ff     <= '0;
         lg_ff        <= rhs_pkg::SIZE_LOG2_RESET;
         limit_ff     <= rhs_pkg::LOAD_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         count_ff     <= count_in;
         lg_ff        <= lg_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff  <= kind_in;
      key_ff   <= key_in;
      carry_ff <= carry_in;
      idx_ff   <= idx_in;
      last_ff  <= last_in;
      dist_ff  <= dist_in;
      step_ff  <= step_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != rhs_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ----- design/rhs_checker.sv -----
// Port-level checks for the Robin Hood hash set unit, bound to the top level.
// Depends on rhs_pkg and robin_hood_hash_set_unit_assert.svh.
`include "robin_hood_hash_set_unit_assert.svh"

module rhs_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input rhs_pkg::rsp_type rsp_word,
   input logic             csr_valid,
   input logic             csr_ready,
   input logic             csr_index
);

   logic size_wr;
   logic rsp_hit;

   assign size_wr = csr_valid && csr_ready && (csr_index == rhs_pkg::CSR_SIZE_LOG2);
   assign rsp_hit = rsp_valid && rsp_word.hit;

   `RHS_ASSERT_NEXT_ALWAYS(a_reset_clears, reset, busy && !rsp_valid)
   `RHS_ASSERT_NEXT(a_accept_works, start && !busy, busy || rsp_valid)
   `RHS_ASSERT_IMPL(a_hit_done, rsp_hit, rsp_word.status == rhs_pkg::STAT_DONE)
   `RHS_ASSERT_NEXT(a_size_write_clears, size_wr, busy)

endmodule

bind robin_hood_hash_set_unit rhs_checker u_rhs_checker (.*);
